// ===== rtl/core/assert_macros.svh =====
// Assertion macros for RTL files that check their own logic.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/cbn_pkg.sv =====
// Package for the coverage bitmap novelty block: sizes, codes, command and
// status types, and the bucketing and bit count functions. No dependencies.
`default_nettype none
package cbn_pkg;

   localparam int MAP_WORDS = 262144;
   localparam int ADDR_W    = $clog2(MAP_WORDS);
   localparam int IDX_W     = 18;
   localparam int EXT_W     = (IDX_W > ADDR_W) ? IDX_W + 1 : ADDR_W + 1;
   localparam int WORD_W    = 64;
   localparam int COUNT_W   = 25;
   localparam int HIT_W     = 7;

   localparam logic [1:0] KIND_CLASSIFY = 2'd0;
   localparam logic [1:0] KIND_SESSION  = 2'd1;
   localparam logic [1:0] KIND_RESTORE  = 2'd2;

   localparam logic [1:0] NOV_NONE   = 2'd0;
   localparam logic [1:0] NOV_COUNTS = 2'd1;
   localparam logic [1:0] NOV_BYTES  = 2'd2;

   // Controller to datapath commands.
   typedef struct packed {
      logic clear;
      logic load_in;
      logic rd;
      logic check;
      logic load_out;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clear_end;
      logic out_busy;
   } status_type;

   // Power-of-two class of one hit-count byte.
   function automatic logic [7:0] bucket_byte(input logic [7:0] b);
      logic [7:0] r;
      if (b == 8'd0)       r = 8'd0;
      else if (b == 8'd1)  r = 8'd1;
      else if (b == 8'd2)  r = 8'd2;
      else if (b == 8'd3)  r = 8'd4;
      else if (b < 8'd8)   r = 8'd8;
      else if (b < 8'd16)  r = 8'd16;
      else if (b < 8'd32)  r = 8'd32;
      else if (b < 8'd128) r = 8'd64;
      else                 r = 8'd128;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] bucket_word(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = bucket_byte(w[8*i +: 8]);
      end
      return r;
   endfunction

   // Count set bits: per byte, then sum the eight byte counts.
   function automatic logic [HIT_W-1:0] count_ones(input logic [WORD_W-1:0] v);
      logic [3:0]       bc;
      logic [HIT_W-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         bc = '0;
         for (int j = 0; j < 8; j++) begin
            bc = bc + 4'(v[8*i + j]);
         end
         n = n + HIT_W'(bc);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cbn_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on cbn_pkg for field widths.
`default_nettype none
interface cbn_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [cbn_pkg::IDX_W-1:0] word_index;
   logic [cbn_pkg::WORD_W-1:0] trace_word;
   logic                      last;

   modport source (output valid, kind, word_index, trace_word, last, input ready);
   modport sink   (input valid, kind, word_index, trace_word, last, output ready);
endinterface

interface cbn_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cbn_pkg::WORD_W-1:0]  classified_word;
   logic [1:0]                  novelty;
   logic [cbn_pkg::COUNT_W-1:0] covered_bits;
   logic                        pass_done;

   modport source (output valid, classified_word, novelty, covered_bits, pass_done,
                   input ready);
   modport sink   (input valid, classified_word, novelty, covered_bits, pass_done,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cbn_ctrl.sv =====
// Sequencing state machine: clearing pass, accept, read, check, result load.
// Depends on cbn_pkg for the command and status types.
`default_nettype none
module cbn_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cbn_pkg::status_type status,
   output cbn_pkg::cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_ACC   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/cbn_datapath.sv =====
// Datapath: untouched maps, bucketing, hit check, counters, output register.
// Depends on cbn_pkg; driven by commands from cbn_ctrl.
`default_nettype none
module cbn_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cbn_pkg::cmd_type             cmd,
   output cbn_pkg::status_type               status,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [cbn_pkg::IDX_W-1:0]    req_word_index,
   input  wire logic [cbn_pkg::WORD_W-1:0]   req_trace_word,
   input  wire logic                         req_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [cbn_pkg::WORD_W-1:0]        rsp_classified_word,
   output logic [1:0]                        rsp_novelty,
   output logic [cbn_pkg::COUNT_W-1:0]       rsp_covered_bits,
   output logic                              rsp_pass_done
);

   localparam int AW = cbn_pkg::ADDR_W;
   localparam int WW = cbn_pkg::WORD_W;
   localparam int CW = cbn_pkg::COUNT_W;

   logic [WW-1:0] g_mem [cbn_pkg::MAP_WORDS];
   logic [WW-1:0] s_mem [cbn_pkg::MAP_WORDS];

   logic [1:0]                 kind_ff;
   logic [AW-1:0]              addr_ff;
   logic                       inside_ff;
   logic [WW-1:0]              word_ff;
   logic                       last_ff;
   logic [WW-1:0]              cls_ff;
   logic [WW-1:0]              g_rd_ff, s_rd_ff;
   logic [cbn_pkg::HIT_W-1:0]  hit_cnt_ff;
   logic [1:0]                 pass_nov_ff, pass_nov_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [AW-1:0]              clr_cnt_ff;
   logic                       rsp_valid_ff;
   logic [WW-1:0]              out_word_ff;
   logic [1:0]                 out_nov_ff;
   logic [CW-1:0]              out_count_ff;
   logic                       out_last_ff;

   logic [cbn_pkg::EXT_W-1:0]  idx_ext;
   logic                       is_classify, is_session, is_restore;
   logic [WW-1:0]              chk_word, chk_map, hit;
   logic                       fresh_byte;
   logic [1:0]                 level;
   logic [CW:0]                sum;
   logic                       g_we, s_we;
   logic [AW-1:0]              wr_addr;
   logic [WW-1:0]              g_wd, s_wd;

   assign idx_ext     = cbn_pkg::EXT_W'(req_word_index);
   assign is_classify = (kind_ff == cbn_pkg::KIND_CLASSIFY);
   assign is_session  = (kind_ff == cbn_pkg::KIND_SESSION);
   assign is_restore  = (kind_ff == cbn_pkg::KIND_RESTORE);

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         kind_ff   <= req_kind;
         addr_ff   <= idx_ext[AW-1:0];
         inside_ff <= (idx_ext < cbn_pkg::EXT_W'(cbn_pkg::MAP_WORDS));
         word_ff   <= req_trace_word;
         last_ff   <= req_last;
      end
   end

   // Read both maps and bucket the trace word
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         g_rd_ff <= g_mem[addr_ff];
         s_rd_ff <= s_mem[addr_ff];
         cls_ff  <= cbn_pkg::bucket_word(word_ff);
      end
   end

   // Hit check against the selected map; an index past the map reads as covered
   always_comb begin
      chk_word = is_classify ? cls_ff : word_ff;
      chk_map  = '0;
      if (inside_ff && is_classify) chk_map = g_rd_ff;
      else if (inside_ff && is_session) chk_map = s_rd_ff;
      hit = chk_word & chk_map;
      fresh_byte = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (chk_word[8*i +: 8] != 8'd0 && chk_map[8*i +: 8] == 8'hff) fresh_byte = 1'b1;
      end
      level = fresh_byte ? cbn_pkg::NOV_BYTES : cbn_pkg::NOV_COUNTS;
   end

   // Map write port: clearing sweep or the check write-back
   always_comb begin
      wr_addr = cmd.clear ? clr_cnt_ff : addr_ff;
      g_we    = cmd.clear || (cmd.check && inside_ff && is_classify);
      s_we    = cmd.clear || (cmd.check && inside_ff && (is_session || is_restore));
      g_wd    = cmd.clear ? '1 : (chk_map & ~chk_word);
      s_wd    = (cmd.clear || is_restore) ? '1 : (chk_map & ~chk_word);
   end

   always_ff @(posedge clock) begin
      if (g_we) g_mem[wr_addr] <= g_wd;
   end

   always_ff @(posedge clock) begin
      if (s_we) s_mem[wr_addr] <= s_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.check) hit_cnt_ff <= is_classify ? cbn_pkg::count_ones(hit) : '0;
   end

   // Pass novelty: raise on check, drop after the last transaction of a pass
   always_comb begin
      pass_nov_in = pass_nov_ff;
      if (cmd.check && hit != '0 && level > pass_nov_ff) pass_nov_in = level;
      if (cmd.load_out && last_ff) pass_nov_in = cbn_pkg::NOV_NONE;
   end

   // Saturating covered-bit counter
   always_comb begin
      sum      = {1'b0, count_ff} + (CW + 1)'(hit_cnt_ff);
      count_in = sum[CW] ? '1 : sum[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_nov_ff <= cbn_pkg::NOV_NONE;
         count_ff    <= '0;
         clr_cnt_ff  <= '0;
      end else begin
         pass_nov_ff <= pass_nov_in;
         if (cmd.load_out) count_ff <= count_in;
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_out) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_word_ff  <= is_classify ? cls_ff : word_ff;
         out_nov_ff   <= pass_nov_ff;
         out_count_ff <= count_in;
         out_last_ff  <= last_ff;
      end
   end

   assign status.clear_end = (clr_cnt_ff == AW'(cbn_pkg::MAP_WORDS - 1));
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_classified_word = out_word_ff;
   assign rsp_novelty         = out_nov_ff;
   assign rsp_covered_bits    = out_count_ff;
   assign rsp_pass_done       = out_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/coverage_bitmap_novelty.sv =====
// Coverage bitmap novelty checker.
// req_chan carries one transaction per trace word: kind, word_index, trace_word,
// last. rsp_chan returns one transaction per request: classified_word, the
// running pass novelty, the covered-bit count and pass_done.
// Each request passes through accept, map read, check and write-back, and result
// load. The response is registered at the result load, and the next request is
// accepted in the cycle after the result load; no request is taken before the
// last one is through, as each untouched map has a single read and write port.
// After reset both untouched maps are swept to all ones, one word per cycle,
// with req ready low until the last map word is written.
// A stalled receiver holds the result in the output register; one more request
// is accepted and worked up to its result load, where it waits for the slot.
`default_nettype none
`include "assert_macros.svh"
module coverage_bitmap_novelty (
   input  wire logic clock,
   input  wire logic reset,
   cbn_req_if.sink   req_chan,
   cbn_rsp_if.source rsp_chan
);

   cbn_pkg::cmd_type    cmd;
   cbn_pkg::status_type status;

   cbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbn_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_chan.kind),
      .req_word_index      (req_chan.word_index),
      .req_trace_word      (req_chan.trace_word),
      .req_last            (req_chan.last),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_classified_word (rsp_chan.classified_word),
      .rsp_novelty         (rsp_chan.novelty),
      .rsp_covered_bits    (rsp_chan.covered_bits),
      .rsp_pass_done       (rsp_chan.pass_done)
   );

   // No request accepted during the clearing sweep
   `ASSERT_IMPL(a_no_accept_in_clear, cmd.clear, !req_chan.ready)
   // A waiting result is never overwritten
   `ASSERT_IMPL(a_no_overwrite, cmd.load_out, !(rsp_chan.valid && !rsp_chan.ready))
   // An accepted request is read from the maps in the next cycle
   `ASSERT_NEXT(a_read_follows_accept, cmd.load_in, cmd.rd)

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for coverage_bitmap_novelty: directed and random trace-word transactions
// checked against a predictor of bucketing, untouched-map clearing and pass novelty.
// Depends on cbn_pkg, the cbn_req_if / cbn_rsp_if interfaces and the block's RTL.
module tb;
   import cbn_pkg::*;

   localparam int          CLOCK_HALF     = 10;
   localparam int          RESET_CYCLES   = 4;
   // The map sweep after reset alone keeps req ready low while it writes every map word.
   localparam int          WATCHDOG_LIMIT = 4 * MAP_WORDS;
   localparam int          DRAIN_CYCLES   = 16;
   localparam int          RANDOM_ITEMS   = 1100;
   localparam int          HOT_WORDS      = 24;
   localparam int unsigned COUNT_LIMIT    = (1 << COUNT_W) - 1;
   localparam logic [1:0]  KIND_UNUSED    = 2'd3;

   typedef logic [WORD_W-1:0] word_t;

   typedef struct {
      word_t              classified;
      logic [1:0]         novelty;
      logic [COUNT_W-1:0] covered;
      logic               pass_done;
   } novelty_rsp_t;

   logic clock;
   logic reset;

   cbn_req_if req_bus ();
   cbn_rsp_if rsp_bus ();

   coverage_bitmap_novelty u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predictor state: words absent from the maps are still all ones.
   word_t        global_fresh [int];
   word_t        session_fresh [int];
   logic [1:0]   pass_level = NOV_NONE;
   int unsigned  covered_total = 0;

   novelty_rsp_t predicted_rsp_q [$];
   int           error_count = 0;
   int           quiet_cycles = 0;
   int           stall_mode = 0;
   int           stall_left = 0;

   initial clock = 1'b0;
   always #CLOCK_HALF clock = ~clock;

   // Power-of-two class of one hit count.
   function automatic logic [7:0] bucket_class(input logic [7:0] b);
      if (b <= 8'd2) return b;
      if (b == 8'd3) return 8'd4;
      if (b >= 8'd128) return 8'd128;
      if (b >= 8'd32) return 8'd64;
      // 4..31: the power of two just above the leading one
      for (int k = 4; k >= 2; k--) begin
         if (b[k]) return 8'd1 << (k + 1);
      end
      return 8'd0;
   endfunction

   function automatic word_t class_of_word(input word_t w);
      word_t r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = bucket_class(w[8*i +: 8]);
      end
      return r;
   endfunction

   // Merge one word into a map word: raise the pass level, clear shared bits.
   function automatic int unsigned absorb_trace(input word_t w, input word_t fresh,
                                                output word_t remaining);
      word_t      hit;
      logic [1:0] level;
      hit       = w & fresh;
      remaining = fresh;
      if (hit == '0) return 0;
      level = NOV_COUNTS;
      for (int i = 0; i < 8; i++) begin
         if (w[8*i +: 8] != 8'd0 && fresh[8*i +: 8] == 8'hff) level = NOV_BYTES;
      end
      if (level > pass_level) pass_level = level;
      remaining = fresh & ~w;
      return $countones(hit);
   endfunction

   function automatic novelty_rsp_t predict_novelty(input logic [1:0] kind,
                                                    input logic [IDX_W-1:0] idx,
                                                    input word_t word, input logic last);
      novelty_rsp_t r;
      word_t        fresh;
      word_t        remaining;
      int unsigned  gained;
      bit           in_map;
      in_map       = int'(idx) < MAP_WORDS;
      r.classified = word;
      case (kind)
         KIND_CLASSIFY: begin
            r.classified = class_of_word(word);
            if (in_map) begin
               fresh  = global_fresh.exists(int'(idx)) ? global_fresh[int'(idx)] : '1;
               gained = absorb_trace(r.classified, fresh, remaining);
               global_fresh[int'(idx)] = remaining;
               covered_total = (covered_total + gained > COUNT_LIMIT) ?
                               COUNT_LIMIT : covered_total + gained;
            end
         end
         KIND_SESSION: begin
            if (in_map) begin
               fresh  = session_fresh.exists(int'(idx)) ? session_fresh[int'(idx)] : '1;
               gained = absorb_trace(word, fresh, remaining);
               session_fresh[int'(idx)] = remaining;
            end
         end
         KIND_RESTORE: begin
            if (in_map) session_fresh[int'(idx)] = '1;
         end
         default: ;
      endcase
      r.novelty   = pass_level;
      r.covered   = COUNT_W'(covered_total);
      r.pass_done = last;
      // Close the pass after its last word.
      if (last) pass_level = NOV_NONE;
      return r;
   endfunction

   // Drive one transaction and hold it until accepted; valid stays high on return.
   task automatic send_trace(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                             input word_t word, input logic last);
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.word_index <= idx;
      req_bus.trace_word <= word;
      req_bus.last       <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted_rsp_q.push_back(predict_novelty(kind, idx, word, last));
   endtask

   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   // Hold off the sender until every predicted response has come back.
   task automatic wait_for_responses();
      idle_for(1);
      while (predicted_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Mostly sparse hit counts across every class, sometimes a fully random word.
   function automatic word_t random_trace();
      word_t w;
      int    pick;
      if ($urandom_range(0, 99) < 15) return {$urandom, $urandom};
      for (int i = 0; i < 8; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      w[8*i +: 8] = 8'd0;
         else if (pick < 75) w[8*i +: 8] = 8'($urandom_range(1, 3));
         else if (pick < 90) w[8*i +: 8] = 8'($urandom_range(4, 31));
         else                w[8*i +: 8] = 8'($urandom_range(32, 255));
      end
      return w;
   endfunction

   // Every class boundary, both index extremes, then new bytes versus new counts.
   task automatic test_bucket_classes();
      send_trace(KIND_CLASSIFY, '0, 64'h0706_0504_0302_0100, 1'b0);
      send_trace(KIND_CLASSIFY, IDX_W'(1), 64'hff80_7f20_1f10_0f08, 1'b0);
      send_trace(KIND_CLASSIFY, IDX_W'(MAP_WORDS - 1), '1, 1'b0);
      send_trace(KIND_CLASSIFY, '0, '0, 1'b1);
      send_trace(KIND_CLASSIFY, IDX_W'(7), 64'h01, 1'b1);
      send_trace(KIND_CLASSIFY, IDX_W'(7), 64'h02, 1'b1);
      send_trace(KIND_CLASSIFY, IDX_W'(7), 64'h03, 1'b1);
      send_trace(KIND_CLASSIFY, IDX_W'(7), 64'h01, 1'b1);
   endtask

   // Raw words against the session map, then restore a word and see it fresh again.
   task automatic test_session_map();
      send_trace(KIND_SESSION, IDX_W'(5), 64'h00ff_0000_0000_0011, 1'b1);
      send_trace(KIND_SESSION, IDX_W'(5), 64'h13, 1'b1);
      send_trace(KIND_SESSION, IDX_W'(5), 64'h13, 1'b1);
      send_trace(KIND_RESTORE, IDX_W'(5), 64'h0123_4567_89ab_cdef, 1'b0);
      send_trace(KIND_SESSION, IDX_W'(5), 64'h13, 1'b1);
      send_trace(KIND_SESSION, IDX_W'(MAP_WORDS - 1), '1, 1'b0);
      send_trace(KIND_RESTORE, IDX_W'(MAP_WORDS - 1), '0, 1'b1);
   endtask

   // Unused kind passes the word through, keeps the running level and closes a pass.
   task automatic test_unused_kind();
      send_trace(KIND_UNUSED, IDX_W'(9), 64'h0123_4567_89ab_cdef, 1'b0);
      send_trace(KIND_CLASSIFY, IDX_W'(9), 64'h40, 1'b0);
      send_trace(KIND_UNUSED, IDX_W'(9), '1, 1'b1);
      send_trace(KIND_UNUSED, '0, '0, 1'b1);
   endtask

   // Bursts over a small set of hot words so the maps fill up and novelty drops off.
   task automatic test_random_traffic(input int n_items);
      int               hot_idx [HOT_WORDS];
      int               burst_left;
      int               pick;
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
      foreach (hot_idx[i]) hot_idx[i] = $urandom_range(0, MAP_WORDS - 1);
      hot_idx[0] = 0;
      hot_idx[1] = MAP_WORDS - 1;
      burst_left = 0;
      for (int sent = 0; sent < n_items; sent++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
         end
         burst_left--;
         if (sent == n_items / 2) wait_for_responses();
         pick = $urandom_range(0, 99);
         if (pick < 55)      kind = KIND_CLASSIFY;
         else if (pick < 78) kind = KIND_SESSION;
         else if (pick < 90) kind = KIND_RESTORE;
         else                kind = KIND_UNUSED;
         if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom);
         else idx = IDX_W'(hot_idx[$urandom_range(0, HOT_WORDS - 1)]);
         send_trace(kind, idx, random_trace(), $urandom_range(0, 9) == 0);
      end
   endtask

   // Receiver stall pattern: switch between modes at random intervals.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_bus.ready <= (stall_left[3:0] == 4'd0);
      endcase
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      novelty_rsp_t want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (predicted_rsp_q.size() == 0) begin
            $error("response transaction with no prediction pending");
            error_count++;
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_bus.classified_word !== want.classified) begin
               $error("classified_word: expected %h, actual %h",
                      want.classified, rsp_bus.classified_word);
               error_count++;
            end
            if (rsp_bus.novelty !== want.novelty) begin
               $error("novelty: expected %0d, actual %0d", want.novelty, rsp_bus.novelty);
               error_count++;
            end
            if (rsp_bus.covered_bits !== want.covered) begin
               $error("covered_bits: expected %0d, actual %0d",
                      want.covered, rsp_bus.covered_bits);
               error_count++;
            end
            if (rsp_bus.pass_done !== want.pass_done) begin
               $error("pass_done: expected %b, actual %b", want.pass_done, rsp_bus.pass_done);
               error_count++;
            end
         end
      end
   end

   // Abort when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_CLASSIFY;
      req_bus.word_index = '0;
      req_bus.trace_word = '0;
      req_bus.last       = 1'b0;
      rsp_bus.ready      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bucket_classes();
      test_session_map();
      test_unused_kind();
      wait_for_responses();
      test_random_traffic(RANDOM_ITEMS);

      // Drain, then give stray responses a chance to show up.
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
